// ===== hdl/fspd_pkg.sv =====
// Shared types, constants and defaults for the Floyd-Steinberg palette ditherer.
package fspd_pkg;

    // Default values for the top-level parameters
    localparam int PALETTE_SIZE_DEFAULT = 8;
    localparam int LINE_MAX_DEFAULT     = 2048;
    localparam int FRAC_BITS_DEFAULT    = 4;

    // Fixed field and register widths
    localparam int CHAN_W      = 8;
    localparam int INDEX_W     = 3;
    localparam int PAIR_COUNT  = 4;
    localparam int PAIR_W      = 48;
    localparam int ENTRY_W     = 24;
    localparam int COUNT_W     = 4;
    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CMP_W       = 16;

    // Register reset values
    localparam logic [COUNT_W-1:0]  PALETTE_COUNT_RESET = COUNT_W'(8);
    localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RESET   = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RESET  = HEIGHT_W'(480);

    typedef logic [PAIR_COUNT-1:0][PAIR_W-1:0] palette_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PAIR_0,
        CFG_PAIR_1,
        CFG_PAIR_2,
        CFG_PAIR_3,
        CFG_PALETTE_COUNT,
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT
    } cfg_reg_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SEARCH,
        ST_ERR,
        ST_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic sum;
        logic step;
        logic err;
        logic finish;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic search_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/fspd_cfg.sv =====
// Configuration register bank: palette pairs, palette count and image size.
module fspd_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fspd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fspd_pkg::PAIR_W-1:0]          cfg_data,
    output fspd_pkg::palette_t                   palette_pairs,
    output logic [fspd_pkg::COUNT_W-1:0]         palette_count,
    output logic [fspd_pkg::WIDTH_W-1:0]         image_width,
    output logic [fspd_pkg::HEIGHT_W-1:0]        image_height
);

    fspd_pkg::palette_t                  pal_reg;
    logic [fspd_pkg::COUNT_W-1:0]        count_reg;
    logic [fspd_pkg::WIDTH_W-1:0]        width_reg;
    logic [fspd_pkg::HEIGHT_W-1:0]       height_reg;

    // Always take writes
    assign cfg_ready = 1'b1;

    // Decode and store register writes; drop unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pal_reg    <= '0;
            count_reg  <= fspd_pkg::PALETTE_COUNT_RESET;
            width_reg  <= fspd_pkg::IMAGE_WIDTH_RESET;
            height_reg <= fspd_pkg::IMAGE_HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (fspd_pkg::cfg_reg_t'(cfg_index))
                fspd_pkg::CFG_PAIR_0:        pal_reg[0] <= cfg_data;
                fspd_pkg::CFG_PAIR_1:        pal_reg[1] <= cfg_data;
                fspd_pkg::CFG_PAIR_2:        pal_reg[2] <= cfg_data;
                fspd_pkg::CFG_PAIR_3:        pal_reg[3] <= cfg_data;
                fspd_pkg::CFG_PALETTE_COUNT: count_reg  <= cfg_data[fspd_pkg::COUNT_W-1:0];
                fspd_pkg::CFG_IMAGE_WIDTH:   width_reg  <= cfg_data[fspd_pkg::WIDTH_W-1:0];
                fspd_pkg::CFG_IMAGE_HEIGHT:  height_reg <= cfg_data[fspd_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    assign palette_pairs = pal_reg;
    assign palette_count = count_reg;
    assign image_width   = width_reg;
    assign image_height  = height_reg;

endmodule

// ===== hdl/fspd_ctrl.sv =====
// Controller state machine: sequences one pixel through sum, search, error and finish.
module fspd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  fspd_pkg::dp_status_t   status,
    output fspd_pkg::dp_cmd_t      cmd
);

    fspd_pkg::state_t state_reg;
    fspd_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fspd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            fspd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = fspd_pkg::ST_SUM;
                end
            end
            fspd_pkg::ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = fspd_pkg::ST_SEARCH;
            end
            fspd_pkg::ST_SEARCH: begin
                if (status.search_done) begin
                    state_next = fspd_pkg::ST_ERR;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            fspd_pkg::ST_ERR: begin
                cmd.err    = 1'b1;
                state_next = fspd_pkg::ST_FINISH;
            end
            fspd_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = fspd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fspd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/fspd_datapath.sv =====
// Datapath: error sum and clamp, palette search, error diffusion, line store and output register.
module fspd_datapath #(
    parameter int PALETTE_SIZE        = fspd_pkg::PALETTE_SIZE_DEFAULT,
    parameter int LINE_MAX            = fspd_pkg::LINE_MAX_DEFAULT,
    parameter int ERROR_FRACTION_BITS = fspd_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fspd_pkg::dp_cmd_t                 cmd,
    output fspd_pkg::dp_status_t              status,
    input  logic [fspd_pkg::CHAN_W-1:0]       s_red_in,
    input  logic [fspd_pkg::CHAN_W-1:0]       s_green_in,
    input  logic [fspd_pkg::CHAN_W-1:0]       s_blue_in,
    input  fspd_pkg::palette_t                palette_pairs,
    input  logic [fspd_pkg::COUNT_W-1:0]      palette_count,
    input  logic [fspd_pkg::WIDTH_W-1:0]      image_width,
    input  logic [fspd_pkg::HEIGHT_W-1:0]     image_height,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fspd_pkg::INDEX_W-1:0]      m_palette_index,
    output logic [fspd_pkg::CHAN_W-1:0]       m_red_out,
    output logic [fspd_pkg::CHAN_W-1:0]       m_green_out,
    output logic [fspd_pkg::CHAN_W-1:0]       m_blue_out,
    output logic                              m_row_end,
    output logic                              m_frame_end
);

    localparam int F      = ERROR_FRACTION_BITS;
    localparam int ERR_W  = 9 + F;
    localparam int SUM_W  = ERR_W + 2;
    localparam int V_W    = 8 + F;
    localparam int DIST_W = 2 * ERR_W;
    localparam int PROD_W = ERR_W + 3;
    localparam int COL_W  = $clog2(LINE_MAX);
    localparam int MEM_W  = 3 * ERR_W;
    localparam int CW     = fspd_pkg::CHAN_W;
    localparam int IW     = fspd_pkg::INDEX_W;
    localparam int NW     = fspd_pkg::COUNT_W;
    localparam int HW     = fspd_pkg::HEIGHT_W;
    localparam int XW     = fspd_pkg::CMP_W;
    localparam int EW     = fspd_pkg::ENTRY_W;
    localparam logic [V_W-1:0] FULL_SCALE = {8'hFF, {F{1'b0}}};

    // Position and diffusion state
    logic [COL_W-1:0]          col_reg;
    logic [HW-1:0]             row_reg;
    logic signed [ERR_W-1:0]   right_reg      [3];
    logic signed [ERR_W-1:0]   below_left_reg [3];
    logic signed [ERR_W-1:0]   below_reg      [3];

    // Working registers of one pixel
    logic [CW-1:0]             pix_reg   [3];
    logic [V_W-1:0]            v_reg     [3];
    logic signed [ERR_W-1:0]   here_reg  [3];
    logic signed [ERR_W-1:0]   s1_reg    [3];

    // Line store
    logic [MEM_W-1:0]          mem [LINE_MAX];
    logic [MEM_W-1:0]          rd_data_reg;
    logic                      mem_we;
    logic [COL_W-1:0]          mem_addr;
    logic [MEM_W-1:0]          mem_wdata;

    // Search pipeline
    logic [NW-1:0]             a_idx_reg;
    logic [DIST_W-1:0]         d_reg;
    logic [IW-1:0]             d_idx_reg;
    logic                      d_valid_reg;
    logic [DIST_W-1:0]         best_d_reg;
    logic [IW-1:0]             best_idx_reg;
    logic                      best_valid_reg;

    // Output register
    logic                      m_valid_reg;
    logic [IW-1:0]             out_idx_reg;
    logic [CW-1:0]             out_red_reg;
    logic [CW-1:0]             out_green_reg;
    logic [CW-1:0]             out_blue_reg;
    logic                      out_row_end_reg;
    logic                      out_frame_end_reg;

    // Combinational
    logic [XW-1:0]             w_eff;
    logic [HW-1:0]             h_eff;
    logic [NW-1:0]             n_eff;
    logic                      last_col;
    logic                      last_row;
    logic signed [SUM_W-1:0]   sum_c     [3];
    logic [V_W-1:0]            clamp_c   [3];
    logic [EW-1:0]             cand_rgb;
    logic [EW-1:0]             best_rgb;
    logic signed [ERR_W-1:0]   diff_c    [3];
    logic signed [DIST_W-1:0]  sq_c      [3];
    logic [DIST_W-1:0]         cand_dist;
    logic signed [ERR_W-1:0]   err_c     [3];
    logic signed [PROD_W-1:0]  ex_c      [3];
    logic signed [PROD_W-1:0]  e7_c      [3];
    logic signed [PROD_W-1:0]  e5_c      [3];
    logic signed [PROD_W-1:0]  e3_c      [3];
    logic signed [PROD_W-1:0]  sh7_c     [3];
    logic signed [PROD_W-1:0]  sh5_c     [3];
    logic signed [PROD_W-1:0]  sh3_c     [3];
    logic signed [PROD_W-1:0]  sh1_c     [3];
    logic signed [ERR_W-1:0]   left_c    [3];
    logic signed [ERR_W-1:0]   here_c    [3];

    // Sanitize sizes and locate the pixel
    always_comb begin
        w_eff = XW'(image_width);
        if (w_eff == '0) begin
            w_eff = XW'(1);
        end else if (w_eff > XW'(LINE_MAX)) begin
            w_eff = XW'(LINE_MAX);
        end
        h_eff = (image_height == '0) ? HW'(1) : image_height;
        n_eff = palette_count;
        if (n_eff == '0) begin
            n_eff = NW'(1);
        end else if (n_eff > NW'(PALETTE_SIZE)) begin
            n_eff = NW'(PALETTE_SIZE);
        end
    end

    assign last_col = XW'(col_reg) >= (w_eff - XW'(1));
    assign last_row = row_reg >= (h_eff - HW'(1));

    // Add diffused error and clamp to full scale
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic signed [ERR_W-1:0] line_err;
            line_err = (row_reg != '0) ? $signed(rd_data_reg[c*ERR_W +: ERR_W]) : '0;
            sum_c[c] = $signed({3'b000, pix_reg[c], {F{1'b0}}})
                     + $signed({{2{right_reg[c][ERR_W-1]}}, right_reg[c]})
                     + $signed({{2{line_err[ERR_W-1]}}, line_err});
            if (sum_c[c] < 0) begin
                clamp_c[c] = '0;
            end else if (sum_c[c] > $signed({3'b000, FULL_SCALE})) begin
                clamp_c[c] = FULL_SCALE;
            end else begin
                clamp_c[c] = sum_c[c][V_W-1:0];
            end
        end
    end

    // Distance of the candidate entry
    always_comb begin
        logic [fspd_pkg::PAIR_W-1:0] pair;
        pair     = palette_pairs[a_idx_reg[IW-1:1]];
        cand_rgb = a_idx_reg[0] ? pair[2*EW-1:EW] : pair[EW-1:0];
        for (int c = 0; c < 3; c++) begin
            diff_c[c] = $signed({1'b0, v_reg[c]})
                      - $signed({1'b0, cand_rgb[16-8*c +: CW], {F{1'b0}}});
            sq_c[c]   = diff_c[c] * diff_c[c];
        end
        cand_dist = $unsigned(sq_c[0]) + $unsigned(sq_c[1]) + $unsigned(sq_c[2]);
    end

    // Residual error and its four shares, each rounded toward minus infinity
    always_comb begin
        logic [fspd_pkg::PAIR_W-1:0] bpair;
        bpair    = palette_pairs[best_idx_reg[IW-1:1]];
        best_rgb = best_idx_reg[0] ? bpair[2*EW-1:EW] : bpair[EW-1:0];
        for (int c = 0; c < 3; c++) begin
            err_c[c]  = $signed({1'b0, v_reg[c]})
                      - $signed({1'b0, best_rgb[16-8*c +: CW], {F{1'b0}}});
            ex_c[c]   = $signed({{3{err_c[c][ERR_W-1]}}, err_c[c]});
            e7_c[c]   = (ex_c[c] <<< 3) - ex_c[c];
            e5_c[c]   = (ex_c[c] <<< 2) + ex_c[c];
            e3_c[c]   = (ex_c[c] <<< 1) + ex_c[c];
            sh7_c[c]  = e7_c[c] >>> F;
            sh5_c[c]  = e5_c[c] >>> F;
            sh3_c[c]  = e3_c[c] >>> F;
            sh1_c[c]  = ex_c[c] >>> F;
            left_c[c] = below_left_reg[c] + $signed(sh3_c[c][ERR_W-1:0]);
            here_c[c] = below_reg[c] + $signed(sh5_c[c][ERR_W-1:0]);
        end
    end

    // Line store write port: left neighbor during error step, this column at row end
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = col_reg;
        mem_wdata = {here_reg[2], here_reg[1], here_reg[0]};
        if (cmd.err) begin
            mem_we    = !last_row && (col_reg != '0);
            mem_addr  = col_reg - COL_W'(1);
            mem_wdata = {left_c[2], left_c[1], left_c[0]};
        end else if (cmd.finish) begin
            mem_we    = !last_row && last_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rd_data_reg <= mem[col_reg];
        end
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
    end

    // Latch pixel, clamp result and error shares
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pix_reg[0] <= s_red_in;
            pix_reg[1] <= s_green_in;
            pix_reg[2] <= s_blue_in;
        end
        for (int c = 0; c < 3; c++) begin
            if (cmd.sum) begin
                v_reg[c] <= clamp_c[c];
            end
            if (cmd.err) begin
                here_reg[c] <= here_c[c];
                s1_reg[c]   <= $signed(sh1_c[c][ERR_W-1:0]);
            end
        end
    end

    // Search: stage one measures an entry, stage two keeps the nearest
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_idx_reg      <= '0;
            d_valid_reg    <= 1'b0;
            best_valid_reg <= 1'b0;
        end else if (cmd.sum) begin
            a_idx_reg      <= '0;
            d_valid_reg    <= 1'b0;
            best_valid_reg <= 1'b0;
        end else if (cmd.step) begin
            if (a_idx_reg < n_eff) begin
                d_reg       <= cand_dist;
                d_idx_reg   <= a_idx_reg[IW-1:0];
                d_valid_reg <= 1'b1;
                a_idx_reg   <= a_idx_reg + NW'(1);
            end else begin
                d_valid_reg <= 1'b0;
            end
            if (d_valid_reg && (!best_valid_reg || d_reg < best_d_reg)) begin
                best_d_reg     <= d_reg;
                best_idx_reg   <= d_idx_reg;
                best_valid_reg <= 1'b1;
            end
        end
    end

    assign status.search_done = (a_idx_reg >= n_eff) && !d_valid_reg;
    assign status.out_free    = !m_valid_reg || m_ready;

    // Diffusion state and position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            for (int c = 0; c < 3; c++) begin
                right_reg[c]      <= '0;
                below_left_reg[c] <= '0;
                below_reg[c]      <= '0;
            end
        end else begin
            if (cmd.err) begin
                for (int c = 0; c < 3; c++) begin
                    right_reg[c] <= last_col ? '0 : $signed(sh7_c[c][ERR_W-1:0]);
                end
            end
            if (cmd.finish) begin
                for (int c = 0; c < 3; c++) begin
                    if (last_row || last_col) begin
                        below_left_reg[c] <= '0;
                        below_reg[c]      <= '0;
                    end else begin
                        below_left_reg[c] <= here_reg[c];
                        below_reg[c]      <= s1_reg[c];
                    end
                end
                if (last_col) begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + HW'(1);
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    // Output register: load on finish, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_idx_reg       <= best_idx_reg;
            out_red_reg       <= best_rgb[23:16];
            out_green_reg     <= best_rgb[15:8];
            out_blue_reg      <= best_rgb[7:0];
            out_row_end_reg   <= last_col;
            out_frame_end_reg <= last_col && last_row;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_palette_index = out_idx_reg;
    assign m_red_out       = out_red_reg;
    assign m_green_out     = out_green_reg;
    assign m_blue_out      = out_blue_reg;
    assign m_row_end       = out_row_end_reg;
    assign m_frame_end     = out_frame_end_reg;

endmodule

// ===== hdl/floyd_steinberg_palette_dither.sv =====
// Top level of the Floyd-Steinberg palette ditherer.
//
// Pixels enter in raster order on the s_ channel (valid/ready, one RGB item per
// pixel). Each pixel gets its diffused error, is clamped, and is mapped to the
// nearest of the active palette entries; the m_ channel returns its index, its
// color and row/frame end flags, one item per pixel in order.
// Palette, palette count and image size are written on the cfg_ channel; cfg_ready is
// always high. The user must write them while the block is idle; it does not enforce this.
// The search measures one palette entry per cycle through a two-stage distance and
// compare pipeline, over the N active palette entries. One pixel is in work at a
// time: a new pixel is not accepted before the previous one has finished.
// Reset clears the position counters and the carried error and restores the
// register defaults; the line store needs no clearing, since the first row of
// every image does not read it.
// A stalled receiver holds the finished item in the output register; the next
// pixel is still accepted and worked on, and waits only if it finishes before
// the previous item has been taken.
module floyd_steinberg_palette_dither #(
    parameter int PALETTE_SIZE        = fspd_pkg::PALETTE_SIZE_DEFAULT,
    parameter int LINE_MAX            = fspd_pkg::LINE_MAX_DEFAULT,
    parameter int ERROR_FRACTION_BITS = fspd_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [fspd_pkg::CHAN_W-1:0]          s_red_in,
    input  logic [fspd_pkg::CHAN_W-1:0]          s_green_in,
    input  logic [fspd_pkg::CHAN_W-1:0]          s_blue_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [fspd_pkg::INDEX_W-1:0]         m_palette_index,
    output logic [fspd_pkg::CHAN_W-1:0]          m_red_out,
    output logic [fspd_pkg::CHAN_W-1:0]          m_green_out,
    output logic [fspd_pkg::CHAN_W-1:0]          m_blue_out,
    output logic                                 m_row_end,
    output logic                                 m_frame_end,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fspd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fspd_pkg::PAIR_W-1:0]          cfg_data
);

    fspd_pkg::palette_t                  palette_pairs;
    logic [fspd_pkg::COUNT_W-1:0]        palette_count;
    logic [fspd_pkg::WIDTH_W-1:0]        image_width;
    logic [fspd_pkg::HEIGHT_W-1:0]       image_height;
    fspd_pkg::dp_cmd_t                   cmd;
    fspd_pkg::dp_status_t                status;

    // Configuration registers
    fspd_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .palette_pairs (palette_pairs),
        .palette_count (palette_count),
        .image_width   (image_width),
        .image_height  (image_height)
    );

    // Sequencer
    fspd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic, line store and output register
    fspd_datapath #(
        .PALETTE_SIZE        (PALETTE_SIZE),
        .LINE_MAX            (LINE_MAX),
        .ERROR_FRACTION_BITS (ERROR_FRACTION_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_red_in        (s_red_in),
        .s_green_in      (s_green_in),
        .s_blue_in       (s_blue_in),
        .palette_pairs   (palette_pairs),
        .palette_count   (palette_count),
        .image_width     (image_width),
        .image_height    (image_height),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_palette_index (m_palette_index),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out),
        .m_row_end       (m_row_end),
        .m_frame_end     (m_frame_end)
    );

endmodule

// ===== tb/sv/fspd_dither_checker.sv =====
// Checker for the palette ditherer: predicts each pixel's result and compares it.
`timescale 1ns / 1ps

module fspd_dither_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [fspd_pkg::CHAN_W-1:0]      s_red_in,
    input  logic [fspd_pkg::CHAN_W-1:0]      s_green_in,
    input  logic [fspd_pkg::CHAN_W-1:0]      s_blue_in,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [fspd_pkg::INDEX_W-1:0]     m_palette_index,
    input  logic [fspd_pkg::CHAN_W-1:0]      m_red_out,
    input  logic [fspd_pkg::CHAN_W-1:0]      m_green_out,
    input  logic [fspd_pkg::CHAN_W-1:0]      m_blue_out,
    input  logic                             m_row_end,
    input  logic                             m_frame_end,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [fspd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fspd_pkg::PAIR_W-1:0]      cfg_data,
    output int                               mismatch_count,
    output int                               pending_pixels
);

    localparam int PAL_ENTRIES = fspd_pkg::PALETTE_SIZE_DEFAULT;
    localparam int LINE_DEPTH  = fspd_pkg::LINE_MAX_DEFAULT;
    localparam int FRAC        = fspd_pkg::FRAC_BITS_DEFAULT;
    localparam int FULL_LEVEL  = 255 << FRAC;

    // One color channel of diffused error, signed fixed point
    typedef logic signed [8+FRAC:0] err_t;

    typedef struct packed {
        logic [fspd_pkg::INDEX_W-1:0] index;
        logic [fspd_pkg::CHAN_W-1:0]  red;
        logic [fspd_pkg::CHAN_W-1:0]  green;
        logic [fspd_pkg::CHAN_W-1:0]  blue;
        logic                         row_end;
        logic                         frame_end;
    } pixel_result_t;

    // Register copies
    fspd_pkg::palette_t            pal_pairs;
    logic [fspd_pkg::COUNT_W-1:0]  pal_count;
    logic [fspd_pkg::WIDTH_W-1:0]  img_width;
    logic [fspd_pkg::HEIGHT_W-1:0] img_height;

    // Position and carried error
    int   col_pos;
    int   row_pos;
    err_t carry_right [3];
    err_t pend_below_left [3];
    err_t pend_below [3];
    err_t line_err [LINE_DEPTH][3];

    pixel_result_t expected_pixels [$];
    pixel_result_t oldest;

    task automatic clear_state();
        pal_pairs  = '0;
        pal_count  = fspd_pkg::PALETTE_COUNT_RESET;
        img_width  = fspd_pkg::IMAGE_WIDTH_RESET;
        img_height = fspd_pkg::IMAGE_HEIGHT_RESET;
        col_pos    = 0;
        row_pos    = 0;
        for (int c = 0; c < 3; c++) begin
            carry_right[c]     = '0;
            pend_below_left[c] = '0;
            pend_below[c]      = '0;
        end
        expected_pixels.delete();
        mismatch_count = 0;
    endtask

    task automatic write_register(input logic [fspd_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [fspd_pkg::PAIR_W-1:0] data);
        case (idx) inside
            fspd_pkg::CFG_PAIR_0, fspd_pkg::CFG_PAIR_1,
            fspd_pkg::CFG_PAIR_2, fspd_pkg::CFG_PAIR_3: begin
                pal_pairs[idx[1:0]] = data;
            end
            fspd_pkg::CFG_PALETTE_COUNT: begin
                pal_count = data[fspd_pkg::COUNT_W-1:0];
            end
            fspd_pkg::CFG_IMAGE_WIDTH: begin
                img_width = data[fspd_pkg::WIDTH_W-1:0];
            end
            fspd_pkg::CFG_IMAGE_HEIGHT: begin
                img_height = data[fspd_pkg::HEIGHT_W-1:0];
            end
            default: begin
                // unused index: no register behind it
            end
        endcase
    endtask

    // Diffuse, clamp, pick the nearest entry and spread the residual
    function automatic pixel_result_t dither_pixel(
        input logic [3*fspd_pkg::CHAN_W-1:0] rgb_in);
        int            w, h, n, x, best, best_dist, sq_dist, diff;
        int            share3, share5, share1, here;
        int            level [3];
        int            resid [3];
        logic [fspd_pkg::ENTRY_W-1:0] color, best_color;
        logic          last_col, last_row;
        pixel_result_t res;

        w = (img_width == 0) ? 1 : int'(img_width);
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        h = (img_height == 0) ? 1 : int'(img_height);
        n = (pal_count == 0) ? 1 : int'(pal_count);
        if (n > PAL_ENTRIES) n = PAL_ENTRIES;
        x = (col_pos >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_pos;
        last_col = (x >= w - 1);
        last_row = (row_pos >= h - 1);

        // add carried error, clamp to the channel range
        for (int c = 0; c < 3; c++) begin
            level[c] = (int'(rgb_in[16 - 8 * c +: 8]) << FRAC) + int'(carry_right[c]);
            if (row_pos > 0) level[c] += int'(line_err[x][c]);
            if (level[c] < 0) level[c] = 0;
            if (level[c] > FULL_LEVEL) level[c] = FULL_LEVEL;
        end

        // nearest entry, lowest index wins a tie
        best       = 0;
        best_dist  = 0;
        best_color = '0;
        for (int i = 0; i < n; i++) begin
            color   = pal_pairs[i / 2][(i % 2) * fspd_pkg::ENTRY_W +: fspd_pkg::ENTRY_W];
            sq_dist = 0;
            for (int c = 0; c < 3; c++) begin
                diff = level[c] - (int'(color[16 - 8 * c +: 8]) << FRAC);
                sq_dist += diff * diff;
            end
            if (i == 0 || sq_dist < best_dist) begin
                best_dist  = sq_dist;
                best       = i;
                best_color = color;
            end
        end

        // spread the residual; shares round toward minus infinity
        for (int c = 0; c < 3; c++) begin
            resid[c] = level[c] - (int'(best_color[16 - 8 * c +: 8]) << FRAC);
            carry_right[c] = last_col ? err_t'(0) : err_t'((resid[c] * 7) >>> FRAC);
            if (!last_row) begin
                share3 = (resid[c] * 3) >>> FRAC;
                share5 = (resid[c] * 5) >>> FRAC;
                share1 = resid[c] >>> FRAC;
                here   = int'(pend_below[c]) + share5;
                if (x > 0) line_err[x-1][c] = err_t'(int'(pend_below_left[c]) + share3);
                if (last_col) begin
                    line_err[x][c]     = err_t'(here);
                    pend_below_left[c] = '0;
                    pend_below[c]      = '0;
                end else begin
                    pend_below_left[c] = err_t'(here);
                    pend_below[c]      = err_t'(share1);
                end
            end else begin
                pend_below_left[c] = '0;
                pend_below[c]      = '0;
            end
        end

        res.index     = fspd_pkg::INDEX_W'(best);
        res.red       = best_color[23:16];
        res.green     = best_color[15:8];
        res.blue      = best_color[7:0];
        res.row_end   = last_col;
        res.frame_end = last_col && last_row;

        // advance position, wrap at row and frame ends
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = x + 1;
        end
        return res;
    endfunction

    task automatic check_field(input string field, input logic [fspd_pkg::CHAN_W-1:0] want,
                               input logic [fspd_pkg::CHAN_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // Compare results first, then take config and new pixels
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result item with no pixel outstanding");
                    mismatch_count++;
                end else begin
                    oldest = expected_pixels.pop_front();
                    check_field("palette_index", fspd_pkg::CHAN_W'(oldest.index),
                                fspd_pkg::CHAN_W'(m_palette_index));
                    check_field("red_out", oldest.red, m_red_out);
                    check_field("green_out", oldest.green, m_green_out);
                    check_field("blue_out", oldest.blue, m_blue_out);
                    check_field("row_end", fspd_pkg::CHAN_W'(oldest.row_end),
                                fspd_pkg::CHAN_W'(m_row_end));
                    check_field("frame_end", fspd_pkg::CHAN_W'(oldest.frame_end),
                                fspd_pkg::CHAN_W'(m_frame_end));
                end
            end
            if (cfg_valid && cfg_ready) begin
                write_register(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                expected_pixels = {expected_pixels,
                                   dither_pixel({s_red_in, s_green_in, s_blue_in})};
            end
        end
        pending_pixels = expected_pixels.size();
    end

endmodule

// ===== tb/sv/floyd_steinberg_palette_dither_tb.sv =====
// Testbench top for the palette ditherer: clock, reset, pixel and config stimulus, verdict.
`timescale 1ns / 1ps

module floyd_steinberg_palette_dither_tb;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 32;
    localparam int RANDOM_ITEMS = 400;
    localparam logic [fspd_pkg::CFG_INDEX_W-1:0] CFG_BEYOND_LAST =
        fspd_pkg::CFG_INDEX_W'(fspd_pkg::CFG_IMAGE_HEIGHT) + 1'b1;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    logic [fspd_pkg::CHAN_W-1:0]      s_red_in;
    logic [fspd_pkg::CHAN_W-1:0]      s_green_in;
    logic [fspd_pkg::CHAN_W-1:0]      s_blue_in;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [fspd_pkg::INDEX_W-1:0]     m_palette_index;
    logic [fspd_pkg::CHAN_W-1:0]      m_red_out;
    logic [fspd_pkg::CHAN_W-1:0]      m_green_out;
    logic [fspd_pkg::CHAN_W-1:0]      m_blue_out;
    logic                             m_row_end;
    logic                             m_frame_end;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [fspd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [fspd_pkg::PAIR_W-1:0]      cfg_data;

    int mismatch_count;
    int pending_pixels;
    int cycle_count = 0;
    int pixels_sent;
    int send_gap_pct;
    int recv_stall_pct;

    // palette as last written, for pixels placed near entries
    logic [fspd_pkg::PAIR_W-1:0] pal_shadow [fspd_pkg::PAIR_COUNT];

    floyd_steinberg_palette_dither u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_red_in        (s_red_in),
        .s_green_in      (s_green_in),
        .s_blue_in       (s_blue_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_palette_index (m_palette_index),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out),
        .m_row_end       (m_row_end),
        .m_frame_end     (m_frame_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    fspd_dither_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_red_in        (s_red_in),
        .s_green_in      (s_green_in),
        .s_blue_in       (s_blue_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_palette_index (m_palette_index),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out),
        .m_row_end       (m_row_end),
        .m_frame_end     (m_frame_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_pixels  (pending_pixels)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Present one pixel, hold it until accepted; valid stays high on return
    task automatic send_pixel(input logic [3*fspd_pkg::CHAN_W-1:0] rgb);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_red_in   <= rgb[23:16];
        s_green_in <= rgb[15:8];
        s_blue_in  <= rgb[7:0];
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
        @(negedge aclk);
    endtask

    // Write a register once the block has drained
    task automatic write_reg(input logic [fspd_pkg::CFG_INDEX_W-1:0] reg_index,
                             input logic [fspd_pkg::PAIR_W-1:0] data);
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_pixels != 0);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (reg_index < fspd_pkg::PAIR_COUNT) pal_shadow[reg_index[1:0]] = data;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Pixel content: noise, channel extremes, or close to a palette entry
    function automatic logic [3*fspd_pkg::CHAN_W-1:0] random_pixel(input int content);
        logic [3*fspd_pkg::CHAN_W-1:0] rgb;
        logic [fspd_pkg::ENTRY_W-1:0]  entry;
        int                            sel, ch;
        rgb = 24'($urandom);
        if ($urandom_range(0, 7) != 0) begin
            if (content == 1) begin
                for (int c = 0; c < 3; c++) rgb[8*c +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end else if (content == 2) begin
                sel   = $urandom_range(0, 7);
                entry = pal_shadow[sel / 2][(sel % 2) * fspd_pkg::ENTRY_W +: fspd_pkg::ENTRY_W];
                for (int c = 0; c < 3; c++) begin
                    ch = int'(entry[8*c +: 8]) + $urandom_range(0, 32) - 16;
                    if (ch < 0) ch = 0;
                    if (ch > 255) ch = 255;
                    rgb[8*c +: 8] = 8'(ch);
                end
            end
        end
        return rgb;
    endfunction

    // One image in raster order, now and then narrowed or cut short midway
    task automatic send_frame(input int frame_w, input int frame_h);
        int row_w, next_w, last_row_idx, r, c, new_height, content;
        int narrow_row, narrow_col, short_row, short_col;
        row_w        = frame_w;
        next_w       = frame_w;
        last_row_idx = frame_h - 1;
        narrow_row   = -1;
        narrow_col   = -1;
        short_row    = -1;
        short_col    = -1;
        content      = $urandom_range(0, 2);
        if (frame_w > 1 && $urandom_range(0, 3) == 0) begin
            narrow_row = $urandom_range(0, frame_h - 1);
            narrow_col = $urandom_range(1, frame_w - 1);
        end
        if ($urandom_range(0, 5) == 0) begin
            short_row = $urandom_range(0, frame_h - 1);
            short_col = $urandom_range(0, frame_w - 1);
        end
        r = 0;
        while (r <= last_row_idx) begin
            c = 0;
            while (c < row_w) begin
                // shrink width so that this pixel ends its row
                if (r == narrow_row && c == narrow_col) begin
                    next_w = $urandom_range(1, c + 1);
                    write_reg(fspd_pkg::CFG_IMAGE_WIDTH, fspd_pkg::PAIR_W'(next_w));
                    row_w = c + 1;
                end
                // shrink height so that this row ends the image
                if (r == short_row && c == short_col) begin
                    new_height = $urandom_range(1, r + 1);
                    write_reg(fspd_pkg::CFG_IMAGE_HEIGHT, fspd_pkg::PAIR_W'(new_height));
                    last_row_idx = r;
                end
                send_pixel(random_pixel(content));
                c++;
            end
            row_w = next_w;
            r++;
        end
    endtask

    // New palette, count and image size for the next image
    task automatic pick_frame_setup(output int frame_w, output int frame_h);
        int count;
        if ($urandom_range(0, 2) == 0) begin
            for (int p = 0; p < fspd_pkg::PAIR_COUNT; p++) begin
                write_reg(fspd_pkg::CFG_INDEX_W'(int'(fspd_pkg::CFG_PAIR_0) + p),
                          fspd_pkg::PAIR_W'({$urandom, $urandom}));
            end
            // duplicate entries to force ties
            if ($urandom_range(0, 3) == 0) write_reg(fspd_pkg::CFG_PAIR_1, pal_shadow[0]);
        end
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        write_reg(fspd_pkg::CFG_PALETTE_COUNT, fspd_pkg::PAIR_W'(count));
        frame_w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        frame_h = $urandom_range(1, 6);
        write_reg(fspd_pkg::CFG_IMAGE_WIDTH, fspd_pkg::PAIR_W'(frame_w));
        write_reg(fspd_pkg::CFG_IMAGE_HEIGHT, fspd_pkg::PAIR_W'(frame_h));
    endtask

    initial begin
        int frame_w, frame_h, target;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_red_in       = '0;
        s_green_in     = '0;
        s_blue_in      = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        pixels_sent    = 0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        for (int p = 0; p < fspd_pkg::PAIR_COUNT; p++) pal_shadow[p] = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset defaults: all-black palette, every entry ties
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000000);
        send_pixel(24'hFF0080);
        // Extreme colors, entry 5 duplicates entry 0
        write_reg(fspd_pkg::CFG_PAIR_0, {24'hFFFFFF, 24'h000000});
        write_reg(fspd_pkg::CFG_PAIR_1, {24'h00FF00, 24'hFF0000});
        write_reg(fspd_pkg::CFG_PAIR_2, {24'h000000, 24'h0000FF});
        write_reg(fspd_pkg::CFG_PAIR_3, {24'hFFFF00, 24'h808080});
        // Zero count acts as one entry
        write_reg(fspd_pkg::CFG_PALETTE_COUNT, '0);
        send_pixel(24'hC8C8C8);
        // Oversized count with junk in the upper bits
        write_reg(fspd_pkg::CFG_PALETTE_COUNT, '1);
        send_pixel(24'h0AFA0A);
        send_pixel(24'h000000);
        // Zero width mid-row: the current column is past the end
        write_reg(fspd_pkg::CFG_IMAGE_WIDTH, '0);
        write_reg(CFG_BEYOND_LAST, '1);
        send_pixel(24'hFFFFFF);
        // Zero height: the second row is now the last
        write_reg(fspd_pkg::CFG_IMAGE_HEIGHT, '0);
        send_pixel(24'h00FF00);
        // 2x2 image, width written with junk above its field
        write_reg(fspd_pkg::CFG_IMAGE_WIDTH, 48'hFFFF_FFFF_F002);
        write_reg(fspd_pkg::CFG_IMAGE_HEIGHT, 48'd2);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h7F7F7F);
        send_pixel(24'h000000);
        send_pixel(24'hFF00FF);
        // Oversized width and full height, both cut short later
        write_reg(fspd_pkg::CFG_IMAGE_WIDTH, 48'd4095);
        write_reg(fspd_pkg::CFG_IMAGE_HEIGHT, 48'd65535);
        send_pixel(24'hFFFFFF);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h010101);
        send_pixel(24'hFEFEFE);
        write_reg(fspd_pkg::CFG_IMAGE_WIDTH, 48'd3);
        send_pixel(24'h808080);
        write_reg(fspd_pkg::CFG_IMAGE_HEIGHT, 48'd2);
        send_pixel(24'h00FFFF);
        send_pixel(24'hFF8000);
        send_pixel(24'h000000);

        // Random images under each idling mode
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 52; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 52; end
                default: begin send_gap_pct = 16; recv_stall_pct = 16; end
            endcase
            target = pixels_sent + RANDOM_ITEMS / 4;
            while (pixels_sent < target) begin
                pick_frame_setup(frame_w, frame_h);
                send_frame(frame_w, frame_h);
            end
        end

        // Drain, then give the verdict
        s_valid <= 1'b0;
        while (pending_pixels != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
